>>> hw/rtl/tcbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared codes, pool handshake structs and elaboration-time helpers for the block pool allocator.
package tcbpa_pkg;

  localparam int unsigned ADDR_W = 32;

  // Request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Size classes for allocate
  localparam logic [1:0] CLASS_SMALL  = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_BIG    = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SMALL_BASE  = 2'd0;
  localparam logic [1:0] REG_MEDIUM_BASE = 2'd1;
  localparam logic [1:0] REG_BIG_BASE    = 2'd2;

  // Result field widths
  localparam int unsigned SMALL_USED_W  = 7;
  localparam int unsigned MEDIUM_USED_W = 5;
  localparam int unsigned BIG_USED_W    = 3;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [ADDR_W-1:0] addr;
  } pool_cmd_t;

  typedef struct packed {
    logic              ready;
    logic              match;
    logic              pop_ok;
    logic [ADDR_W-1:0] block_addr;
  } pool_stat_t;

  // Number of zero bits below the lowest set bit.
  function automatic int unsigned trailing_zeros(input logic [31:0] v);
    int unsigned n;
    logic        found;
    n     = 0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && v[i]) begin
        n     = i;
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd value modulo 2^32 by Newton iteration.
  function automatic logic [31:0] odd_inverse(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/three_class_block_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-class block pool allocator: input register, three pools, result register.
// Flow: each request is held in the input register, then its result in the result register,
//   which drives m_axis; while the output side is stalled the request waits in the input register.
// Throughput: one request per cycle while m_axis_tready is high and no pool is clearing; each
//   pool pops or pushes its list head, with the head's link prefetched from the pool's next-index RAM.
// Reset: rst_ni clears control state asynchronously; each pool then sweeps its whole link RAM,
//   with s_axis_tready low until every pool has finished.
module three_class_block_pool_allocator #(
  parameter int unsigned SMALL_BLOCKS  = 64,
  parameter int unsigned MEDIUM_BLOCKS = 16,
  parameter int unsigned BIG_BLOCKS    = 4,
  parameter int unsigned SMALL_BYTES   = 128,
  parameter int unsigned MEDIUM_BYTES  = 2048,
  parameter int unsigned BIG_BYTES     = 16384
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  // Request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] address
  input  wire  [2:0]  s_axis_tuser,   // [0] command, [2:1] size_class
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] block_address, [38:32] small_used,
                                      // [43:39] medium_used, [46:44] big_used, [47] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [31:0] small_base_q, medium_base_q, big_base_q;

  logic        in_vld_q;
  logic        in_cmd_q;
  logic [1:0]  in_class_q;
  logic [31:0] in_addr_q;

  logic        out_vld_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_status_q;
  logic [tcbpa_pkg::SMALL_USED_W-1:0]  out_small_used_q;
  logic [tcbpa_pkg::MEDIUM_USED_W-1:0] out_medium_used_q;
  logic [tcbpa_pkg::BIG_USED_W-1:0]    out_big_used_q;

  tcbpa_pkg::pool_cmd_t  small_cmd, medium_cmd, big_cmd;
  tcbpa_pkg::pool_stat_t small_stat, medium_stat, big_stat;
  logic [tcbpa_pkg::SMALL_USED_W-1:0]  small_used;
  logic [tcbpa_pkg::MEDIUM_USED_W-1:0] medium_used;
  logic [tcbpa_pkg::BIG_USED_W-1:0]    big_used;

  logic        init_ready, adv, in_accept, is_alloc;
  logic [31:0] res_addr;
  logic [1:0]  res_status;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_base_q  <= '0;
      medium_base_q <= '0;
      big_base_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcbpa_pkg::REG_SMALL_BASE:  small_base_q  <= cfg_data_i;
        tcbpa_pkg::REG_MEDIUM_BASE: medium_base_q <= cfg_data_i;
        tcbpa_pkg::REG_BIG_BASE:    big_base_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: advance the input register whenever the result register is free or draining.
  assign init_ready    = small_stat.ready && medium_stat.ready && big_stat.ready;
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = init_ready && (!in_vld_q || adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_alloc      = (in_cmd_q == tcbpa_pkg::CMD_ALLOC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cmd_q   <= s_axis_tuser[0];
      in_class_q <= s_axis_tuser[2:1];
      in_addr_q  <= s_axis_tdata;
    end
  end

  // Pool requests: a free is offered small first, then medium, then big.
  always_comb begin
    small_cmd.addr  = in_addr_q;
    medium_cmd.addr = in_addr_q;
    big_cmd.addr    = in_addr_q;
    small_cmd.pop   = adv && is_alloc && (in_class_q == tcbpa_pkg::CLASS_SMALL);
    medium_cmd.pop  = adv && is_alloc && (in_class_q == tcbpa_pkg::CLASS_MEDIUM);
    big_cmd.pop     = adv && is_alloc && (in_class_q == tcbpa_pkg::CLASS_BIG);
    small_cmd.push  = adv && !is_alloc;
    medium_cmd.push = adv && !is_alloc && !small_stat.match;
    big_cmd.push    = adv && !is_alloc && !small_stat.match && !medium_stat.match;
  end

  tcbpa_pool #(
    .BLOCKS (SMALL_BLOCKS),
    .BYTES  (SMALL_BYTES),
    .USED_W (tcbpa_pkg::SMALL_USED_W)
  ) u_small_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .base_i (small_base_q),
    .cmd_i  (small_cmd),
    .stat_o (small_stat),
    .used_o (small_used)
  );

  tcbpa_pool #(
    .BLOCKS (MEDIUM_BLOCKS),
    .BYTES  (MEDIUM_BYTES),
    .USED_W (tcbpa_pkg::MEDIUM_USED_W)
  ) u_medium_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .base_i (medium_base_q),
    .cmd_i  (medium_cmd),
    .stat_o (medium_stat),
    .used_o (medium_used)
  );

  tcbpa_pool #(
    .BLOCKS (BIG_BLOCKS),
    .BYTES  (BIG_BYTES),
    .USED_W (tcbpa_pkg::BIG_USED_W)
  ) u_big_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .base_i (big_base_q),
    .cmd_i  (big_cmd),
    .stat_o (big_stat),
    .used_o (big_used)
  );

  // Result selection
  always_comb begin
    res_addr   = '0;
    res_status = tcbpa_pkg::STATUS_DONE;
    if (is_alloc) begin
      case (in_class_q)
        tcbpa_pkg::CLASS_SMALL: begin
          if (small_stat.pop_ok) res_addr = small_stat.block_addr;
          else res_status = tcbpa_pkg::STATUS_EXHAUSTED;
        end
        tcbpa_pkg::CLASS_MEDIUM: begin
          if (medium_stat.pop_ok) res_addr = medium_stat.block_addr;
          else res_status = tcbpa_pkg::STATUS_EXHAUSTED;
        end
        tcbpa_pkg::CLASS_BIG: begin
          if (big_stat.pop_ok) res_addr = big_stat.block_addr;
          else res_status = tcbpa_pkg::STATUS_EXHAUSTED;
        end
        default: res_status = tcbpa_pkg::STATUS_EXHAUSTED;
      endcase
    end else if (!(small_stat.match || medium_stat.match || big_stat.match)) begin
      res_status = tcbpa_pkg::STATUS_NO_MATCH;
    end
  end

  // Result register: hold until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_addr_q        <= res_addr;
      out_status_q      <= res_status;
      out_small_used_q  <= small_used;
      out_medium_used_q <= medium_used;
      out_big_used_q    <= big_used;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_big_used_q, out_medium_used_q, out_small_used_q, out_addr_q};
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> init_ready)
    else $error("request held while pool links are being cleared");

  a_zero_addr_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != tcbpa_pkg::STATUS_DONE)) |-> (m_axis_tdata[31:0] == '0))
    else $error("failed request returned a nonzero block address");

  a_small_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(out_small_used_q) <= 32'(SMALL_BLOCKS)))
    else $error("small used count above pool size");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_vld_q)
    else $error("accepted request lost from input register");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("processed request produced no result");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/tcbpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
module tcbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                    clk_i,
  input  wire                                    we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                       wdata_i,
  input  wire                                    re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/tcbpa_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// One fixed-size block pool: free list in RAM, head and prefetched head link, free counter.
module tcbpa_pool #(
  parameter int unsigned BLOCKS = 64,
  parameter int unsigned BYTES  = 128,
  parameter int unsigned USED_W = 7
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  [31:0]                base_i,
  input  wire  tcbpa_pkg::pool_cmd_t cmd_i,
  output tcbpa_pkg::pool_stat_t      stat_o,
  output logic [USED_W-1:0]          used_o
);

  localparam int unsigned HEAD_W = $clog2(BLOCKS + 1);
  localparam int unsigned IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned TZ     = tcbpa_pkg::trailing_zeros(32'(BYTES));
  localparam logic [31:0] ODD      = 32'(BYTES) >> TZ;
  localparam logic [31:0] INV      = tcbpa_pkg::odd_inverse(ODD);
  localparam logic [31:0] QMAX     = 32'hFFFF_FFFF / ODD;
  localparam logic [31:0] LOW_MASK = (32'd1 << TZ) - 32'd1;
  localparam logic [HEAD_W-1:0] BLOCKS_H = HEAD_W'(BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BLOCKS - 1);

  logic [HEAD_W-1:0] head_q, head_d;
  logic [HEAD_W-1:0] hnext_q, hnext_d;
  logic              pend_q, pend_d;
  logic [HEAD_W-1:0] free_q, free_d;
  logic              clr_q, clr_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;

  logic [HEAD_W-1:0] rd_data;
  logic [HEAD_W-1:0] head_nxt;
  logic              we, re;
  logic [IDX_W-1:0]  waddr;
  logic [HEAD_W-1:0] wdata;

  logic [31:0]       off, scaled, quo;
  logic              match, avail, do_pop, do_push;
  logic [IDX_W-1:0]  push_idx;
  logic [HEAD_W-1:0] used_full;

  // Exact divisibility test: strip the power-of-two part, then multiply by the odd inverse.
  assign off      = cmd_i.addr - base_i;
  assign scaled   = off >> TZ;
  assign quo      = scaled * INV;
  assign match    = (cmd_i.addr >= base_i) && ((off & LOW_MASK) == 32'd0) &&
                    (quo <= QMAX) && (quo < 32'(BLOCKS));
  assign push_idx = quo[IDX_W-1:0];

  // Link of the current head: RAM read data right after a pop, else the held copy.
  assign head_nxt = pend_q ? rd_data : hnext_q;

  assign avail   = (free_q != '0) && (head_q < BLOCKS_H);
  assign do_pop  = cmd_i.pop && avail && !clr_q;
  assign do_push = cmd_i.push && match && !clr_q;

  always_comb begin
    head_d    = head_q;
    hnext_d   = head_nxt;
    pend_d    = 1'b0;
    free_d    = free_q;
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    we        = 1'b0;
    waddr     = push_idx;
    wdata     = head_q;
    re        = 1'b0;
    if (clr_q) begin
      // Sweep the links to their initial chain 0 -> 1 -> ... -> BLOCKS.
      we    = 1'b1;
      waddr = clr_idx_q;
      wdata = HEAD_W'(clr_idx_q) + HEAD_W'(1);
      if (clr_idx_q == LAST_IDX) begin
        clr_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + IDX_W'(1);
      end
    end else if (do_pop) begin
      head_d = head_nxt;
      free_d = free_q - HEAD_W'(1);
      pend_d = 1'b1;
      re     = head_nxt < BLOCKS_H;
    end else if (do_push) begin
      we      = 1'b1;
      head_d  = HEAD_W'(push_idx);
      hnext_d = head_q;
      if (free_q < BLOCKS_H) begin
        free_d = free_q + HEAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      hnext_q   <= HEAD_W'(1);
      pend_q    <= 1'b0;
      free_q    <= BLOCKS_H;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      head_q    <= head_d;
      hnext_q   <= hnext_d;
      pend_q    <= pend_d;
      free_q    <= free_d;
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  tcbpa_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (BLOCKS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (head_nxt[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // Used count after this cycle's request.
  assign used_full = BLOCKS_H - free_d;
  assign used_o    = USED_W'(used_full);

  assign stat_o.ready      = !clr_q;
  assign stat_o.match      = match;
  assign stat_o.pop_ok     = avail;
  assign stat_o.block_addr = base_i + 32'(head_q) * 32'(BYTES);

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-class block pool allocator: random and directed requests.
module testbench;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned N_POOLS     = 3;
  localparam logic [1:0]  CLASS_NONE  = 2'd3;

  typedef struct packed {
    logic                                logic_pad_unused_never;
  } unused_t;

  typedef struct packed {
    logic                                pad;
    logic [tcbpa_pkg::ADDR_W-1:0]        block_address;
    logic [1:0]                          status;
    logic [tcbpa_pkg::SMALL_USED_W-1:0]  small_used;
    logic [tcbpa_pkg::MEDIUM_USED_W-1:0] medium_used;
    logic [tcbpa_pkg::BIG_USED_W-1:0]    big_used;
  } pool_result_t;

  typedef struct packed {
    logic                         from_live;
    logic                         cmd;
    logic [1:0]                   size_class;
    logic [tcbpa_pkg::ADDR_W-1:0] address;
  } pool_request_t;

  typedef struct packed {
    logic [1:0] pool;
    logic [6:0] index;
  } block_ref_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid     = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;

  // Allocator shadow: free lists, heads, free counters and bases
  int unsigned   link_tbl  [N_POOLS][64];
  int unsigned   head_idx  [N_POOLS];
  int unsigned   free_cnt  [N_POOLS];
  logic [31:0]   pool_base [N_POOLS];
  block_ref_t    live_blocks      [$];
  pool_request_t pending_requests [$];
  pool_result_t  expected_results [$];

  logic        req_taken      = 1'b0;
  bit          idle_on        = 1'b1;
  bit          long_hold_done = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned results_seen   = 0;
  int unsigned n_requests     = 0;
  int unsigned n_mismatch     = 0;
  int unsigned n_granted      = 0;
  int unsigned n_exhausted    = 0;
  int unsigned n_returned     = 0;
  int unsigned n_unmatched    = 0;

  three_class_block_pool_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] address
    .s_axis_tuser  (s_axis_tuser),   // [0] command, [2:1] size_class
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] block_address, [38:32] small_used,
                                     // [43:39] medium_used, [46:44] big_used, [47] zero
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned blocks_of(input logic [1:0] pool);
    case (pool)
      tcbpa_pkg::CLASS_SMALL:  return 64;
      tcbpa_pkg::CLASS_MEDIUM: return 16;
      default:                 return 4;
    endcase
  endfunction

  function automatic int unsigned bytes_of(input logic [1:0] pool);
    case (pool)
      tcbpa_pkg::CLASS_SMALL:  return 128;
      tcbpa_pkg::CLASS_MEDIUM: return 2048;
      default:                 return 16384;
    endcase
  endfunction

  function automatic logic [31:0] slot_address(input logic [1:0] pool, input int unsigned index);
    return pool_base[pool] + index * bytes_of(pool);
  endfunction

  // Apply one request to the shadow pools and return the result it should produce.
  function automatic pool_result_t serve_request(input logic cmd, input logic [1:0] cls,
                                                 input logic [31:0] addr);
    pool_result_t r;
    block_ref_t   entry;
    int unsigned  idx;
    logic [31:0]  off;
    bit           taken;
    bit           found;
    r     = '0;
    taken = 1'b0;
    if (cmd == tcbpa_pkg::CMD_ALLOC) begin
      if (cls <= tcbpa_pkg::CLASS_BIG) begin
        idx = head_idx[cls];
        if (free_cnt[cls] != 0 && idx < blocks_of(cls)) begin
          r.block_address = slot_address(cls, idx);
          head_idx[cls]   = link_tbl[cls][idx];
          free_cnt[cls]--;
          entry.pool  = cls;
          entry.index = 7'(idx);
          live_blocks.push_back(entry);
          taken = 1'b1;
          n_granted++;
        end
      end
      if (!taken) begin
        r.status = tcbpa_pkg::STATUS_EXHAUSTED;
        n_exhausted++;
      end
    end else begin
      // offer to small, then medium, then big
      for (int p = 0; p < N_POOLS && !taken; p++) begin
        off = addr - pool_base[p];
        if (addr >= pool_base[p] && off % bytes_of(2'(p)) == 0 &&
            off / bytes_of(2'(p)) < blocks_of(2'(p))) begin
          idx           = off / bytes_of(2'(p));
          link_tbl[p][idx] = head_idx[p];
          head_idx[p]   = idx;
          if (free_cnt[p] < blocks_of(2'(p))) free_cnt[p]++;
          found = 1'b0;
          for (int j = 0; j < live_blocks.size() && !found; j++) begin
            if (live_blocks[j].pool == p && live_blocks[j].index == idx) begin
              live_blocks.delete(j);
              found = 1'b1;
            end
          end
          taken = 1'b1;
          n_returned++;
        end
      end
      if (!taken) begin
        r.status = tcbpa_pkg::STATUS_NO_MATCH;
        n_unmatched++;
      end
    end
    r.small_used  = 7'(blocks_of(tcbpa_pkg::CLASS_SMALL) - free_cnt[tcbpa_pkg::CLASS_SMALL]);
    r.medium_used = 5'(blocks_of(tcbpa_pkg::CLASS_MEDIUM) - free_cnt[tcbpa_pkg::CLASS_MEDIUM]);
    r.big_used    = 3'(blocks_of(tcbpa_pkg::CLASS_BIG) - free_cnt[tcbpa_pkg::CLASS_BIG]);
    return r;
  endfunction

  task automatic queue_request(input logic cmd, input logic [1:0] cls, input logic [31:0] addr);
    pool_request_t req;
    req.from_live  = 1'b0;
    req.cmd        = cmd;
    req.size_class = cls;
    req.address    = addr;
    pending_requests.push_back(req);
  endtask

  // Frees mostly return a live block, picked when the request goes out; the rest is noise.
  task automatic queue_random(input int n, input int alloc_pct);
    pool_request_t req;
    logic [1:0]    p;
    int unsigned   idx;
    int unsigned   roll;
    repeat (n) begin
      req.from_live  = 1'b0;
      req.cmd        = tcbpa_pkg::CMD_ALLOC;
      req.size_class = 2'($urandom_range(0, 3));
      req.address    = $urandom;
      if ($urandom_range(0, 99) < alloc_pct) begin
        roll = $urandom_range(0, 99);
        if (roll < 50)      req.size_class = tcbpa_pkg::CLASS_SMALL;
        else if (roll < 75) req.size_class = tcbpa_pkg::CLASS_MEDIUM;
        else if (roll < 96) req.size_class = tcbpa_pkg::CLASS_BIG;
        else                req.size_class = CLASS_NONE;
      end else begin
        req.cmd = tcbpa_pkg::CMD_FREE;
        p   = 2'($urandom_range(0, 2));
        idx = $urandom_range(0, blocks_of(p) + 2);
        case ($urandom_range(0, 9))
          0: ;
          1: req.address = slot_address(p, idx);
          2: req.address = slot_address(p, idx) + $urandom_range(1, bytes_of(p) - 1);
          3: req.address = pool_base[p] - bytes_of(p);
          default: req.from_live = 1'b1;
        endcase
      end
      pending_requests.push_back(req);
    end
  endtask

  task automatic write_base(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    pool_base[index] = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Request side: hold each transfer until taken, then advance or idle for a burst.
  always @(negedge clk_i) begin : drive_requests
    pool_request_t req;
    bit            offer;
    int unsigned   pick;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      offer = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (idle_on && pending_requests.size() > 0 && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 13);
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        if (req.from_live && live_blocks.size() > 0) begin
          pick        = $urandom_range(0, live_blocks.size() - 1);
          req.address = slot_address(live_blocks[pick].pool, live_blocks[pick].index);
        end
        s_axis_tdata <= req.address;
        s_axis_tuser <= {req.size_class, req.cmd};
        offer = 1'b1;
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result side: one long hold to back the pipeline up, otherwise random bursts.
  always @(negedge clk_i) begin : drive_ready
    bit ready;
    ready = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (!long_hold_done && results_seen >= 300) begin
      hold_left      = LONG_HOLD - 1;
      long_hold_done = 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 13);
    end else begin
      ready = 1'b1;
    end
    m_axis_tready <= ready;
  end

  always @(posedge clk_i) begin : check_results
    pool_result_t got;
    pool_result_t want;
    req_taken <= s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[47], m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32],
             m_axis_tdata[43:39], m_axis_tdata[46:44]};
      results_seen++;
      if (expected_results.size() == 0) begin
        if (n_mismatch < 10)
          $display("%0t: result with nothing pending: addr %h status %0d used %0d/%0d/%0d",
                   $time, got.block_address, got.status, got.small_used, got.medium_used,
                   got.big_used);
        n_mismatch++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (n_mismatch < 10)
            $display({"%0t: mismatch: expected addr %h status %0d used %0d/%0d/%0d pad %b,",
                      " got addr %h status %0d used %0d/%0d/%0d pad %b"}, $time,
                     want.block_address, want.status, want.small_used, want.medium_used,
                     want.big_used, want.pad, got.block_address, got.status, got.small_used,
                     got.medium_used, got.big_used, got.pad);
          n_mismatch++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      n_requests++;
      expected_results.push_back(serve_request(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata));
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run_test
    logic [31:0] rand_base;
    for (int p = 0; p < N_POOLS; p++) begin
      for (int i = 0; i < 64; i++) link_tbl[p][i] = i + 1;
      head_idx[p]  = 0;
      free_cnt[p]  = blocks_of(2'(p));
      pool_base[p] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // All bases at zero: pools overlap, small wins every shared address
    queue_request(tcbpa_pkg::CMD_ALLOC, tcbpa_pkg::CLASS_SMALL,  32'hFFFF_FFFF);
    queue_request(tcbpa_pkg::CMD_ALLOC, tcbpa_pkg::CLASS_SMALL,  32'h0000_0000);
    queue_request(tcbpa_pkg::CMD_ALLOC, tcbpa_pkg::CLASS_MEDIUM, 32'h0000_0000);
    queue_request(tcbpa_pkg::CMD_ALLOC, tcbpa_pkg::CLASS_BIG,    32'h0000_0000);
    queue_request(tcbpa_pkg::CMD_ALLOC, CLASS_NONE,              32'h0000_0000);
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_0080);
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_0080);   // double free
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_0100);   // saturates
    queue_request(tcbpa_pkg::CMD_FREE,  CLASS_NONE,              32'h0000_0001);   // misaligned
    // past small, lands in medium
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_2000);
    // past medium, lands in big
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_8000);
    // past every pool
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0001_0000);
    queue_request(tcbpa_pkg::CMD_FREE,  CLASS_NONE,              32'hFFFF_FFFF);
    // last small block
    queue_request(tcbpa_pkg::CMD_FREE,  tcbpa_pkg::CLASS_SMALL,  32'h0000_1F80);
    repeat (5) queue_request(tcbpa_pkg::CMD_ALLOC, tcbpa_pkg::CLASS_BIG, 32'h0000_0000);
    queue_random(150, 55);
    wait_drained();

    write_base(tcbpa_pkg::REG_SMALL_BASE,  32'h1000_0000);
    write_base(tcbpa_pkg::REG_MEDIUM_BASE, 32'h2000_0000);
    write_base(tcbpa_pkg::REG_BIG_BASE,    32'h3000_0000);
    queue_random(250, 80);
    wait_drained();

    // Small and big bases near the top of the address space: small block addresses wrap
    write_base(tcbpa_pkg::REG_SMALL_BASE,  32'hFFFF_FFFF);
    write_base(tcbpa_pkg::REG_MEDIUM_BASE, 32'h8000_0000);
    write_base(tcbpa_pkg::REG_BIG_BASE,    32'hFFFF_0000);
    queue_random(200, 30);
    wait_drained();

    rand_base = $urandom;
    write_base(tcbpa_pkg::REG_SMALL_BASE,  rand_base);
    write_base(tcbpa_pkg::REG_MEDIUM_BASE, rand_base + $urandom_range(0, 16) * 128);
    write_base(tcbpa_pkg::REG_BIG_BASE,    $urandom);
    queue_random(250, 55);
    wait_drained();

    write_base(tcbpa_pkg::REG_SMALL_BASE,  32'h0000_0000);
    write_base(tcbpa_pkg::REG_MEDIUM_BASE, 32'hFFFF_FFFF);
    write_base(tcbpa_pkg::REG_BIG_BASE,    32'h0000_8000);
    idle_on = 1'b0;
    queue_random(250, 50);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("summary: %0d requests and %0d results over five base settings, one long stall",
             n_requests, results_seen);
    $display("summary: %0d granted, %0d exhausted, %0d returned, %0d unmatched, %0d mismatches",
             n_granted, n_exhausted, n_returned, n_unmatched, n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
